// File: src/chpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpe_pkg
// Shared widths and types of the complex Horner polynomial evaluator.
// ----------------------------------------------------------------------------
package chpe_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ProdW = 2 * WordW;
  localparam int unsigned FracW = 5;

  // s_tdata: point_real, point_imag, coef_real, coef_imag
  localparam int unsigned InDataW  = 4 * WordW;
  // m_tdata: value_real, value_imag
  localparam int unsigned OutDataW = 2 * WordW;

  typedef struct packed {
    logic signed [WordW-1:0] im;
    logic signed [WordW-1:0] re;
  } cplx_t;

  // one coefficient word as held in the input register
  typedef struct packed {
    cplx_t point;
    cplx_t coef;
    logic  first;
    logic  last;
  } item_t;

endpackage

// File: src/chpe_cmac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpe_cmac
// One Horner step: acc * x + coef in complex fixed point, or a plain load of
// the coefficient on the first word of a polynomial.
// ----------------------------------------------------------------------------
module chpe_cmac (
  input  chpe_pkg::cplx_t                  acc,
  input  chpe_pkg::cplx_t                  point,
  input  chpe_pkg::cplx_t                  coef,
  input  logic                             first,
  input  logic [chpe_pkg::FracW-1:0]       frac,
  output chpe_pkg::cplx_t                  acc_next
);

  logic signed [chpe_pkg::ProdW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [chpe_pkg::ProdW-1:0] s_rr, s_ii, s_ri, s_ir;
  logic        [chpe_pkg::WordW-1:0] sum_re, sum_im;

  always_comb begin
    // signed 32x32 products, sign-extended to the full product width
    p_rr = $signed(acc.re) * $signed(point.re);
    p_ii = $signed(acc.im) * $signed(point.im);
    p_ri = $signed(acc.re) * $signed(point.im);
    p_ir = $signed(acc.im) * $signed(point.re);
    // each partial product truncated toward minus infinity on its own
    s_rr = p_rr >>> frac;
    s_ii = p_ii >>> frac;
    s_ri = p_ri >>> frac;
    s_ir = p_ir >>> frac;
    sum_re = s_rr[chpe_pkg::WordW-1:0] - s_ii[chpe_pkg::WordW-1:0] + coef.re;
    sum_im = s_ri[chpe_pkg::WordW-1:0] + s_ir[chpe_pkg::WordW-1:0] + coef.im;
    if (first) begin
      acc_next = coef;
    end else begin
      acc_next.re = sum_re;
      acc_next.im = sum_im;
    end
  end

endmodule

// File: src/complex_horner_polynomial_eval_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_horner_polynomial_eval_unit
// Streams coefficients, highest power first, and emits p(x) on the last one.
// ----------------------------------------------------------------------------
// m_tvalid rises when the last coefficient moves on into the result register.
// Throughput: one coefficient per cycle while s_tready is high; the loop through
//   four 32x32 multipliers and the accumulator register sets this.
// s_tready drops only while a last word waits on a full, stalled output.
// Reset clears the word valids, the accumulator and fraction_bits.
// ----------------------------------------------------------------------------
module complex_horner_polynomial_eval_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [chpe_pkg::FracW-1:0]      cfg_wdata,  // fraction_bits
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // point_real, point_imag, coef_real, coef_imag
  input  logic [chpe_pkg::InDataW-1:0]    s_tdata,
  input  logic [0:0]                      s_tuser,    // first_coef
  input  logic                            s_tlast,    // last_coef
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [chpe_pkg::OutDataW-1:0]   m_tdata     // value_real, value_imag
);

  logic [chpe_pkg::FracW-1:0] frac;
  chpe_pkg::item_t            item;
  logic                       item_valid;
  chpe_pkg::cplx_t            acc, acc_next;
  chpe_pkg::cplx_t            result;
  logic                       result_valid;
  logic                       advance;

  // the held word moves on unless it is a last word facing a stalled output
  assign advance  = item_valid && (!item.last || !result_valid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac <= '0;
    end else if (cfg_wen) begin
      frac <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.point.re <= s_tdata[chpe_pkg::WordW-1:0];
      item.point.im <= s_tdata[2*chpe_pkg::WordW-1:chpe_pkg::WordW];
      item.coef.re  <= s_tdata[3*chpe_pkg::WordW-1:2*chpe_pkg::WordW];
      item.coef.im  <= s_tdata[4*chpe_pkg::WordW-1:3*chpe_pkg::WordW];
      item.first    <= s_tuser[0];
      item.last     <= s_tlast;
    end
  end

  chpe_cmac u_cmac (
    .acc      (acc),
    .point    (item.point),
    .coef     (item.coef),
    .first    (item.first),
    .frac     (frac),
    .acc_next (acc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (advance) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && item.last) begin
      result_valid <= 1'b1;
    end else if (m_tready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      result <= acc_next;
    end
  end

  assign m_tvalid = result_valid;
  assign m_tdata  = {result.im, result.re};

endmodule

// File: src/chpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpe_checker
// Port-level checks of the complex Horner polynomial evaluator.
// ----------------------------------------------------------------------------
module chpe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [chpe_pkg::OutDataW-1:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // reset leaves the output empty and the input open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  // input backpressure only comes from a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output stall");

  // a ready output side never blocks the input
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output ready");

endmodule

bind complex_horner_polynomial_eval_unit chpe_checker u_chpe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
